// File: design/grey_homotopic_thinning_pass_core_macros.svh
// Assertion helpers shared by the thinning core.
`ifndef GREY_HOMOTOPIC_THINNING_PASS_CORE_MACROS_SVH
`define GREY_HOMOTOPIC_THINNING_PASS_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define GHTP_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define GHTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ghtp_pkg.sv
package ghtp_pkg;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 13;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LINE_WIDTH  = 2'd0,
    CFG_LINE_COUNT  = 2'd1,
    CFG_ORIENTATION = 2'd2
  } cfg_index_t;

  localparam int LINE_WIDTH_BITS = 11;
  localparam int LINE_COUNT_BITS = 13;
  localparam int ORIENT_BITS = 3;
  localparam int FIELD_PIXEL_BITS = 16;

  localparam int LINE_WIDTH_RESET = 1024;
  localparam int LINE_COUNT_RESET = 4096;
  localparam int LINE_WIDTH_MIN = 3;
  localparam int LINE_COUNT_MIN = 3;
  localparam int LINE_WIDTH_RAW_MAX = 2 ** LINE_WIDTH_BITS - 1;
  localparam int LINE_COUNT_RAW_MAX = 2 ** LINE_COUNT_BITS - 1;

  // 3x3 cells, row-major, centre is cell 4
  localparam int CELLS = 9;
  localparam int CENTRE_CELL = 4;

  typedef logic [CELLS-1:0] cell_mask_t;

  localparam cell_mask_t LOW_SET [0:7] = '{
    9'h007, 9'h124, 9'h1C0, 9'h049, 9'h022, 9'h0A0, 9'h088, 9'h00A
  };
  localparam cell_mask_t HIGH_SET [0:7] = '{
    9'h1D0, 9'h059, 9'h017, 9'h134, 9'h0D8, 9'h01B, 9'h036, 9'h1B0
  };

  typedef struct packed {
    logic                   thin_en;
    logic [ORIENT_BITS-1:0] orientation;
  } thin_ctl_t;

endpackage

// File: design/ghtp_ram.sv
module ghtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ghtp_window.sv
module ghtp_window #(
  parameter int PIXEL_BITS = 16,
  parameter int W_CAP = 1024,
  localparam int W_BITS = $clog2(W_CAP + 1),
  localparam int ADDR_BITS = $clog2(W_CAP)
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     restart,
  input  logic                                     shift,
  input  logic [PIXEL_BITS-1:0]                    pix,
  input  logic [W_BITS-1:0]                        width,
  output logic [ghtp_pkg::CELLS-1:0][PIXEL_BITS-1:0] taps
);

  // RAM word: upper half is the stream delayed by one line, lower half by two
  logic [ADDR_BITS-1:0]    ptr;
  logic [ADDR_BITS-1:0]    ptr_next;
  logic [W_BITS-1:0]       ptr_inc;
  logic [ADDR_BITS-1:0]    raddr;
  logic [2*PIXEL_BITS-1:0] rdata;
  logic [2*PIXEL_BITS-1:0] wdata;
  logic [PIXEL_BITS-1:0]   line1;
  logic [PIXEL_BITS-1:0]   line2;

  logic [2:0][PIXEL_BITS-1:0] row_new;
  logic [2:0][PIXEL_BITS-1:0] row_mid;
  logic [2:0][PIXEL_BITS-1:0] row_old;

  assign ptr_inc  = W_BITS'(ptr) + W_BITS'(1);
  assign ptr_next = (ptr_inc >= width) ? '0 : ptr_inc[ADDR_BITS-1:0];

  // prefetch the next slot so its word is ready at the next shift
  assign raddr = shift ? ptr_next : ptr;
  assign line1 = rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign line2 = rdata[PIXEL_BITS-1:0];
  assign wdata = {pix, line1};

  ghtp_ram #(
    .WIDTH(2 * PIXEL_BITS),
    .DEPTH(W_CAP)
  ) u_line_ram (
    .clk  (clk),
    .we   (shift),
    .waddr(ptr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // a new row width restarts the ring so the pointer stays inside it
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ptr <= '0;
    end else if (shift) begin
      ptr <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      row_new <= {row_new[1:0], pix};
      row_mid <= {row_mid[1:0], line1};
      row_old <= {row_old[1:0], line2};
    end
  end

  // oldest column on the left: NW N NE / W C E / SW S SE
  assign taps[0] = row_old[2];
  assign taps[1] = row_old[1];
  assign taps[2] = row_old[0];
  assign taps[3] = row_mid[2];
  assign taps[4] = row_mid[1];
  assign taps[5] = row_mid[0];
  assign taps[6] = row_new[2];
  assign taps[7] = row_new[1];
  assign taps[8] = row_new[0];

endmodule

// File: design/ghtp_thin.sv
module ghtp_thin #(
  parameter int PIXEL_BITS = 16
) (
  input  logic [ghtp_pkg::CELLS-1:0][PIXEL_BITS-1:0] taps,
  input  ghtp_pkg::thin_ctl_t                        ctl,
  output logic [PIXEL_BITS-1:0]                      result,
  output logic                                       lowered
);

  logic [PIXEL_BITS-1:0]   dil;
  logic [PIXEL_BITS-1:0]   ero;
  logic [PIXEL_BITS-1:0]   centre;
  ghtp_pkg::cell_mask_t    lo_mask;
  ghtp_pkg::cell_mask_t    hi_mask;

  assign lo_mask = ghtp_pkg::LOW_SET[ctl.orientation];
  assign hi_mask = ghtp_pkg::HIGH_SET[ctl.orientation];
  assign centre  = taps[ghtp_pkg::CENTRE_CELL];

  always_comb begin
    dil = '0;
    ero = '1;
    for (int c = 0; c < ghtp_pkg::CELLS; c++) begin
      if (lo_mask[c] && (taps[c] > dil)) begin
        dil = taps[c];
      end
      if (hi_mask[c] && (taps[c] < ero)) begin
        ero = taps[c];
      end
    end
  end

  assign lowered = ctl.thin_en && (dil < centre) && (ero == centre);
  assign result  = lowered ? dil : centre;

endmodule

// File: design/grey_homotopic_thinning_pass_core.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    pixel_in, flush
// out      out_valid / out_stall  pixel_out, changed, frame_last, frame_changed
// cfg      cfg_we                 cfg_index, cfg_data
//
// One item per cycle unless stalled; line RAM: one write and one prefetch read per cycle.
// A result passes from the thin stage register to the output register; a stall can hold it.
// First result of a frame after line_width+2 pixels; line_width+1 flush items drain the rest.
// Reset clears counters and restores config defaults; the line RAM is not cleared.
// A stalled output blocks input only while the thinning stage also holds a result.
`include "grey_homotopic_thinning_pass_core_macros.svh"

module grey_homotopic_thinning_pass_core #(
  parameter int MAX_WIDTH = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ghtp_pkg::FIELD_PIXEL_BITS-1:0] pixel_in,
  input  logic                                  flush,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ghtp_pkg::FIELD_PIXEL_BITS-1:0] pixel_out,
  output logic                                  changed,
  output logic                                  frame_last,
  output logic                                  frame_changed,
  input  logic                                  cfg_we,
  input  logic [ghtp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ghtp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int W_CAP = (MAX_WIDTH < ghtp_pkg::LINE_WIDTH_RAW_MAX) ?
                         MAX_WIDTH : ghtp_pkg::LINE_WIDTH_RAW_MAX;
  localparam int W_BITS = $clog2(W_CAP + 1);
  localparam int POS_BITS = $clog2(W_CAP * ghtp_pkg::LINE_COUNT_RAW_MAX + 1);
  localparam int W_RST = (ghtp_pkg::LINE_WIDTH_RESET > W_CAP) ?
                         W_CAP : ghtp_pkg::LINE_WIDTH_RESET;
  localparam int TOTAL_RST = W_RST * ghtp_pkg::LINE_COUNT_RESET;

  typedef struct packed {
    logic valid;
    logic thin;
    logic last;
  } stage_t;

  // configuration
  logic [W_BITS-1:0]                    width;
  logic [ghtp_pkg::LINE_COUNT_BITS-1:0] lines;
  logic [POS_BITS-1:0]                  total;
  logic [ghtp_pkg::ORIENT_BITS-1:0]     orient;
  logic [ghtp_pkg::LINE_WIDTH_BITS-1:0] width_raw;
  logic [W_BITS-1:0]                    width_sat;
  logic [ghtp_pkg::LINE_COUNT_BITS-1:0] lines_sat;
  logic                                 width_wr;

  // frame position
  logic [POS_BITS-1:0] in_pos;
  logic [POS_BITS-1:0] out_pos;
  logic                any_seen;
  logic                accept;
  logic                clear;
  logic [POS_BITS-1:0] in_c;
  logic [POS_BITS-1:0] out_c;
  logic                wr;
  logic [POS_BITS-1:0] in_a;
  logic [POS_BITS:0]   far;
  logic                emit;
  logic                thin;
  logic                last;
  logic                shift;

  stage_t s1;
  logic   s1_move;
  logic   out_load_ok;

  logic [ghtp_pkg::CELLS-1:0][PIXEL_BITS-1:0] taps;
  ghtp_pkg::thin_ctl_t                        thin_ctl;
  logic [PIXEL_BITS-1:0]                      result;
  logic                                       lowered;

  // ---------------------------------------------------------------- config
  assign width_raw = cfg_data[ghtp_pkg::LINE_WIDTH_BITS-1:0];
  assign width_sat = (width_raw < ghtp_pkg::LINE_WIDTH_BITS'(ghtp_pkg::LINE_WIDTH_MIN)) ?
                     W_BITS'(ghtp_pkg::LINE_WIDTH_MIN) :
                     ((32'(width_raw) > W_CAP) ? W_BITS'(W_CAP) : W_BITS'(width_raw));
  assign lines_sat = (cfg_data < ghtp_pkg::CFG_DATA_BITS'(ghtp_pkg::LINE_COUNT_MIN)) ?
                     ghtp_pkg::LINE_COUNT_BITS'(ghtp_pkg::LINE_COUNT_MIN) :
                     cfg_data[ghtp_pkg::LINE_COUNT_BITS-1:0];
  assign width_wr  = cfg_we && (cfg_index == ghtp_pkg::CFG_LINE_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= W_BITS'(W_RST);
      lines  <= ghtp_pkg::LINE_COUNT_BITS'(ghtp_pkg::LINE_COUNT_RESET);
      total  <= POS_BITS'(TOTAL_RST);
      orient <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ghtp_pkg::CFG_LINE_WIDTH: begin
          width <= width_sat;
          total <= POS_BITS'(POS_BITS'(width_sat) * POS_BITS'(lines));
        end
        ghtp_pkg::CFG_LINE_COUNT: begin
          lines <= lines_sat;
          total <= POS_BITS'(POS_BITS'(width) * POS_BITS'(lines_sat));
        end
        ghtp_pkg::CFG_ORIENTATION: begin
          orient <= cfg_data[ghtp_pkg::ORIENT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------- position control
  assign accept = in_valid && !in_stall;
  assign clear  = (out_pos >= total) || (in_pos > total);
  assign in_c   = clear ? '0 : in_pos;
  assign out_c  = clear ? '0 : out_pos;
  assign wr     = !flush && (in_c < total);
  assign in_a   = in_c + POS_BITS'(wr);
  assign far    = (POS_BITS+1)'(out_c) + (POS_BITS+1)'(width) + (POS_BITS+1)'(2);
  assign emit   = ((POS_BITS+1)'(in_a) >= far) || (in_a == total);
  assign thin   = (out_c > POS_BITS'(width)) && (far <= (POS_BITS+1)'(total));
  assign last   = ((POS_BITS+1)'(out_c) + (POS_BITS+1)'(1)) == (POS_BITS+1)'(total);
  // past the frame end, advance the window with a dummy so the centre tap stays aligned
  assign shift  = accept && (wr || emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pos  <= '0;
      out_pos <= '0;
    end else if (accept) begin
      if (emit && last) begin
        in_pos  <= '0;
        out_pos <= '0;
      end else if (emit) begin
        in_pos  <= in_a;
        out_pos <= POS_BITS'(out_c + POS_BITS'(1));
      end else begin
        in_pos  <= in_a;
        out_pos <= out_c;
      end
    end
  end

  ghtp_window #(
    .PIXEL_BITS(PIXEL_BITS),
    .W_CAP     (W_CAP)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .restart(width_wr),
    .shift  (shift),
    .pix    (pixel_in[PIXEL_BITS-1:0]),
    .width  (width),
    .taps   (taps)
  );

  // ------------------------------------------------------------ thin stage
  assign out_load_ok = !out_valid || !out_stall;
  assign s1_move     = s1.valid && out_load_ok;
  assign in_stall    = s1.valid && !out_load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (accept && emit) begin
      s1.valid <= 1'b1;
      s1.thin  <= thin;
      s1.last  <= last;
    end else if (s1_move) begin
      s1.valid <= 1'b0;
    end
  end

  assign thin_ctl.thin_en     = s1.thin;
  assign thin_ctl.orientation = orient;

  ghtp_thin #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_thin (
    .taps   (taps),
    .ctl    (thin_ctl),
    .result (result),
    .lowered(lowered)
  );

  // a frame abandoned at transfer time drops the change flag after the older result
  always_ff @(posedge clk) begin
    if (rst) begin
      any_seen <= 1'b0;
    end else if (accept && clear) begin
      any_seen <= 1'b0;
    end else if (s1_move) begin
      any_seen <= s1.last ? 1'b0 : (any_seen || lowered);
    end
  end

  // ------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pixel_out     <= ghtp_pkg::FIELD_PIXEL_BITS'(result);
      changed       <= lowered;
      frame_last    <= s1.last;
      frame_changed <= s1.last && (any_seen || lowered);
    end
  end

  // ------------------------------------------------------------ assertions
  `GHTP_ASSERT_HOLDS(a_out_behind_in, clk, rst, 1'b1, out_pos <= in_pos,
    "output position ran ahead of input position")
  `GHTP_ASSERT_HOLDS(a_last_not_thinned, clk, rst, out_valid && frame_last, !changed,
    "final pixel of a frame reported as thinned")
  `GHTP_ASSERT_HOLDS(a_stall_cause, clk, rst, in_stall,
    s1.valid && out_valid && out_stall, "input stalled without a blocked result")
  `GHTP_ASSERT_NEXT(a_flag_cleared, clk, rst, s1_move && s1.last, !any_seen,
    "frame change flag survived the final pixel")

endmodule
